// ----- rtl/ocp_pkg.sv -----
// Package: shared constants, codes, types and Q16.16 helpers for the contraction block.
`timescale 1ns / 1ps
package ocp_pkg;

  localparam int unsigned MAX_BASIS_DEF = 16;
  localparam int unsigned MAX_OCC_DEF   = 8;
  localparam int unsigned MAX_VIRT_DEF  = 8;

  localparam int unsigned QW       = 32;
  localparam int unsigned CFG_DW   = 5;
  localparam int unsigned CFG_IW   = 2;
  // Cycles from the last issued term until the accumulator is settled.
  localparam int unsigned DRAIN_CYCLES = 5;

  // Input item modes.
  localparam logic [1:0] MODE_COEF    = 2'd0;
  localparam logic [1:0] MODE_POT     = 2'd1;
  localparam logic [1:0] MODE_AMP     = 2'd2;
  localparam logic [1:0] MODE_COMPUTE = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IW-1:0] CFG_BASIS_COUNT = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_OCC_COUNT   = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_VIRT_COUNT  = 2'd2;
  localparam logic [CFG_IW-1:0] CFG_TERM_MODE   = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_ISSUE,
    ST_DRAIN,
    ST_OUT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // write the accepted load beat into its store
    logic clear;    // zero the accumulator
    logic issue;    // start one term at the presented addresses
    logic capture;  // saturate the accumulator into the result register
  } dp_cmd_t;

  // Q16.16 product rounding: add half, floor shift, saturate to 32 bits.
  function automatic logic signed [QW-1:0] q_round(input logic signed [2*QW-1:0] p);
    logic signed [2*QW-1:0] s;
    logic signed [2*QW-17:0] r;
    begin
      s = p + 64'sd32768;
      r = (2*QW-16)'(s >>> 16);
      if (r > (2*QW-16)'(64'sh7fffffff)) begin
        q_round = 32'sh7fffffff;
      end else if (r < -(2*QW-16)'(64'sh80000000)) begin
        q_round = 32'sh80000000;
      end else begin
        q_round = r[QW-1:0];
      end
    end
  endfunction

endpackage

// ----- rtl/ocp_in_if.sv -----
// Interface: input channel carrying load and compute beats.
`timescale 1ns / 1ps
interface ocp_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic [3:0]         row_index;
  logic [3:0]         col_index;
  logic signed [31:0] load_value;

  modport source (output valid, mode, row_index, col_index, load_value, input ready);
  modport sink   (input valid, mode, row_index, col_index, load_value, output ready);
endinterface

// ----- rtl/ocp_out_if.sv -----
// Interface: output channel carrying contraction results.
`timescale 1ns / 1ps
interface ocp_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         occ_index;
  logic [2:0]         virt_index;
  logic signed [31:0] result_value;
  logic               last_result;

  modport source (output valid, occ_index, virt_index, result_value, last_result,
                  input ready);
  modport sink   (input valid, occ_index, virt_index, result_value, last_result,
                  output ready);
endinterface

// ----- rtl/ocp_datapath.sv -----
// Datapath: the three stores, the term multiply pipeline and the accumulator.
`timescale 1ns / 1ps
module ocp_datapath #(
  parameter int unsigned MAX_BASIS = ocp_pkg::MAX_BASIS_DEF,
  parameter int unsigned MAX_OCC   = ocp_pkg::MAX_OCC_DEF,
  parameter int unsigned MAX_VIRT  = ocp_pkg::MAX_VIRT_DEF,
  localparam int unsigned NBANDS = MAX_OCC + MAX_VIRT,
  localparam int unsigned IW = (MAX_BASIS > 1) ? $clog2(MAX_BASIS) : 1,
  localparam int unsigned BW = (NBANDS > 1) ? $clog2(NBANDS) : 1,
  localparam int unsigned OW = (MAX_OCC > 1) ? $clog2(MAX_OCC) : 1,
  localparam int unsigned VW = (MAX_VIRT > 1) ? $clog2(MAX_VIRT) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ocp_pkg::dp_cmd_t     cmd_i,
  input  logic [1:0]           mode_i,
  input  logic [3:0]           row_i,
  input  logic [3:0]           col_i,
  input  logic signed [31:0]   value_i,
  input  logic [OW-1:0]        amp_row_i,
  input  logic [VW-1:0]        amp_col_i,
  input  logic [BW-1:0]        c1_band_i,
  input  logic [IW-1:0]        mu_i,
  input  logic [IW-1:0]        nu_i,
  input  logic [BW-1:0]        c2_band_i,
  output logic signed [31:0]   result_o
);

  localparam int unsigned MW = (MAX_OCC > MAX_VIRT) ? MAX_OCC : MAX_VIRT;
  localparam int unsigned AW = ocp_pkg::QW + 2 * IW + $clog2(MW + 1) + 2;

  logic signed [31:0] coef_mem [NBANDS][MAX_BASIS];
  logic signed [31:0] pot_mem  [MAX_BASIS][MAX_BASIS];
  logic signed [31:0] amp_mem  [MAX_OCC][MAX_VIRT];

  logic signed [31:0] x_q, c1_q, v_q, c2_q, v2_q, c2b_q, c2c_q;
  logic signed [63:0] p1_q, p2_q, p3_q;
  logic               vld1_q, vld2_q, vld3_q, vld4_q;
  logic signed [AW-1:0] acc_q;
  logic signed [31:0] res_q;
  logic [AW-32:0]     acc_hi;

  // Store writes for load beats whose indexes fall inside their store.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      if (mode_i == ocp_pkg::MODE_COEF && int'(row_i) < NBANDS
          && int'(col_i) < MAX_BASIS) begin
        coef_mem[BW'(row_i)][IW'(col_i)] <= value_i;
      end
      if (mode_i == ocp_pkg::MODE_POT && int'(row_i) < MAX_BASIS
          && int'(col_i) < MAX_BASIS) begin
        pot_mem[IW'(row_i)][IW'(col_i)] <= value_i;
      end
      if (mode_i == ocp_pkg::MODE_AMP && int'(row_i) < MAX_OCC
          && int'(col_i) < MAX_VIRT) begin
        amp_mem[OW'(row_i)][VW'(col_i)] <= value_i;
      end
    end
  end

  // Registered store reads; the coefficient store has two read ports.
  always_ff @(posedge clk_i) begin
    x_q  <= amp_mem[amp_row_i][amp_col_i];
    c1_q <= coef_mem[c1_band_i][mu_i];
    v_q  <= pot_mem[nu_i][mu_i];
    c2_q <= coef_mem[c2_band_i][nu_i];
  end

  // Three multiply stages; the second and third round the previous product first.
  always_ff @(posedge clk_i) begin
    p1_q  <= x_q * c1_q;
    v2_q  <= v_q;
    c2b_q <= c2_q;
    p2_q  <= ocp_pkg::q_round(p1_q) * v2_q;
    c2c_q <= c2b_q;
    p3_q  <= ocp_pkg::q_round(p2_q) * c2c_q;
  end

  // Term valid flags travel alongside the multiply stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
      vld4_q <= 1'b0;
    end else begin
      vld1_q <= cmd_i.issue;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
      vld4_q <= vld3_q;
    end
  end

  // Exact wide accumulation of rounded terms.
  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      acc_q <= '0;
    end else if (vld4_q) begin
      acc_q <= acc_q + AW'(ocp_pkg::q_round(p3_q));
    end
  end

  // Saturate the sum to 32 bits when the controller captures it.
  assign acc_hi = acc_q[AW-1:31];
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      if ((&acc_hi) || !(|acc_hi)) begin
        res_q <= acc_q[31:0];
      end else if (acc_q[AW-1]) begin
        res_q <= 32'sh80000000;
      end else begin
        res_q <= 32'sh7fffffff;
      end
    end
  end

  assign result_o = res_q;

endmodule

// ----- rtl/ocp_controller.sv -----
// Controller: configuration registers, loop counters and the sequencing state machine.
`timescale 1ns / 1ps
module ocp_controller #(
  parameter int unsigned MAX_BASIS = ocp_pkg::MAX_BASIS_DEF,
  parameter int unsigned MAX_OCC   = ocp_pkg::MAX_OCC_DEF,
  parameter int unsigned MAX_VIRT  = ocp_pkg::MAX_VIRT_DEF,
  localparam int unsigned NBANDS = MAX_OCC + MAX_VIRT,
  localparam int unsigned IW = (MAX_BASIS > 1) ? $clog2(MAX_BASIS) : 1,
  localparam int unsigned BW = (NBANDS > 1) ? $clog2(NBANDS) : 1,
  localparam int unsigned OW = (MAX_OCC > 1) ? $clog2(MAX_OCC) : 1,
  localparam int unsigned VW = (MAX_VIRT > 1) ? $clog2(MAX_VIRT) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ocp_pkg::CFG_IW-1:0]    cfg_idx_i,
  input  logic [ocp_pkg::CFG_DW-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  input  logic [1:0]                    in_mode_i,
  output logic                          in_ready_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [2:0]                    occ_index_o,
  output logic [2:0]                    virt_index_o,
  output logic                          last_o,
  output ocp_pkg::dp_cmd_t              cmd_o,
  output logic [OW-1:0]                 amp_row_o,
  output logic [VW-1:0]                 amp_col_o,
  output logic [BW-1:0]                 c1_band_o,
  output logic [IW-1:0]                 mu_o,
  output logic [IW-1:0]                 nu_o,
  output logic [BW-1:0]                 c2_band_o
);

  localparam int unsigned MW = (MAX_OCC > MAX_VIRT) ? MAX_OCC : MAX_VIRT;
  localparam int unsigned JW = (MW > 1) ? $clog2(MW) : 1;
  localparam int unsigned DW = $clog2(ocp_pkg::DRAIN_CYCLES);

  ocp_pkg::state_e state_q, state_d;
  logic [4:0]    basis_q;
  logic [3:0]    occ_q, virt_q;
  logic          term_q;
  logic [OW-1:0] i_q;
  logic [VW-1:0] a_q;
  logic [IW-1:0] nu_q, mu_q;
  logic [JW-1:0] j_q;
  logic [DW-1:0] drain_q;
  int unsigned   nb, no, nv, nj;
  logic          in_acc, j_last, mu_last, nu_last, term_last, a_last, i_last;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      basis_q <= 5'd16;
      occ_q   <= 4'd8;
      virt_q  <= 4'd8;
      term_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ocp_pkg::CFG_BASIS_COUNT: basis_q <= cfg_data_i;
        ocp_pkg::CFG_OCC_COUNT:   occ_q   <= cfg_data_i[3:0];
        ocp_pkg::CFG_VIRT_COUNT:  virt_q  <= cfg_data_i[3:0];
        ocp_pkg::CFG_TERM_MODE:   term_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Effective counts: zero acts as one, anything above the store size as the size.
  always_comb begin
    nb = (basis_q == '0) ? 1 : ((int'(basis_q) > MAX_BASIS) ? MAX_BASIS : int'(basis_q));
    no = (occ_q == '0) ? 1 : ((int'(occ_q) > MAX_OCC) ? MAX_OCC : int'(occ_q));
    nv = (virt_q == '0) ? 1 : ((int'(virt_q) > MAX_VIRT) ? MAX_VIRT : int'(virt_q));
    nj = term_q ? nv : no;
  end

  assign in_acc    = in_valid_i && in_ready_o;
  assign j_last    = (int'(j_q) + 1) == nj;
  assign mu_last   = (int'(mu_q) + 1) == nb;
  assign nu_last   = (int'(nu_q) + 1) == nb;
  assign term_last = j_last && mu_last && nu_last;
  assign a_last    = (int'(a_q) + 1) == nv;
  assign i_last    = (int'(i_q) + 1) == no;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ocp_pkg::ST_IDLE:  if (in_acc && in_mode_i == ocp_pkg::MODE_COMPUTE) begin
        state_d = ocp_pkg::ST_CLEAR;
      end
      ocp_pkg::ST_CLEAR: state_d = ocp_pkg::ST_ISSUE;
      ocp_pkg::ST_ISSUE: if (term_last) begin
        state_d = ocp_pkg::ST_DRAIN;
      end
      ocp_pkg::ST_DRAIN: if (int'(drain_q) == ocp_pkg::DRAIN_CYCLES - 1) begin
        state_d = ocp_pkg::ST_OUT;
      end
      ocp_pkg::ST_OUT:   if (out_ready_i) begin
        state_d = (a_last && i_last) ? ocp_pkg::ST_IDLE : ocp_pkg::ST_CLEAR;
      end
      default:           state_d = ocp_pkg::ST_IDLE;
    endcase
  end

  // Outputs and datapath commands.
  always_comb begin
    in_ready_o    = 1'b0;
    out_valid_o   = 1'b0;
    cmd_o         = '0;
    case (state_q)
      ocp_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_acc && in_mode_i != ocp_pkg::MODE_COMPUTE;
      end
      ocp_pkg::ST_CLEAR: cmd_o.clear = 1'b1;
      ocp_pkg::ST_ISSUE: cmd_o.issue = 1'b1;
      ocp_pkg::ST_DRAIN: cmd_o.capture = int'(drain_q) == ocp_pkg::DRAIN_CYCLES - 1;
      ocp_pkg::ST_OUT:   out_valid_o = 1'b1;
      default: ;
    endcase
  end

  // State, loop counters and drain counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ocp_pkg::ST_IDLE;
      i_q     <= '0;
      a_q     <= '0;
      nu_q    <= '0;
      mu_q    <= '0;
      j_q     <= '0;
      drain_q <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        ocp_pkg::ST_IDLE: begin
          i_q <= '0;
          a_q <= '0;
        end
        ocp_pkg::ST_CLEAR: begin
          nu_q    <= '0;
          mu_q    <= '0;
          j_q     <= '0;
          drain_q <= '0;
        end
        ocp_pkg::ST_ISSUE: begin
          if (j_last) begin
            j_q <= '0;
            if (mu_last) begin
              mu_q <= '0;
              nu_q <= nu_q + 1'b1;
            end else begin
              mu_q <= mu_q + 1'b1;
            end
          end else begin
            j_q <= j_q + 1'b1;
          end
        end
        ocp_pkg::ST_DRAIN: drain_q <= drain_q + 1'b1;
        ocp_pkg::ST_OUT: if (out_ready_i) begin
          if (a_last) begin
            a_q <= '0;
            i_q <= i_q + 1'b1;
          end else begin
            a_q <= a_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Store addresses for the current term.
  always_comb begin
    mu_o = mu_q;
    nu_o = nu_q;
    if (term_q) begin
      amp_row_o = i_q;
      amp_col_o = VW'(j_q);
      c1_band_o = BW'(no + int'(j_q));
      c2_band_o = BW'(no + int'(a_q));
    end else begin
      amp_row_o = OW'(j_q);
      amp_col_o = a_q;
      c1_band_o = BW'(i_q);
      c2_band_o = BW'(j_q);
    end
  end

  assign occ_index_o  = 3'(i_q);
  assign virt_index_o = 3'(a_q);
  assign last_o       = a_last && i_last;

endmodule

// ----- rtl/orbital_potential_contraction.sv -----
// Top level: orbital potential contraction, controller plus datapath.
//
// Usage: load beats (mode 0, 1, 2) on the input channel write one entry of the
// coefficient, potential or amplitude store and are taken one per cycle while
// the block is idle. A compute beat (mode 3) starts a run that emits one result
// beat per occupied band i and virtual band a, a inner, with last_result set on
// the final one. Each result clears the accumulator, issues one term per cycle
// (basis_count squared times occupied or virtual count terms) through a single
// shared three-multiplier pipeline, then drains that pipeline and saturates the
// sum. The input channel is not ready during a run. A result beat is held in
// place until the receiver takes it; the run pauses meanwhile. Configuration is
// to be written through the write port while idle; the block does not enforce
// this. Reset returns the controller to idle and the registers to their reset
// values; the stores are not cleared and must be loaded before they are used.
`timescale 1ns / 1ps
module orbital_potential_contraction #(
  parameter int unsigned MAX_BASIS = ocp_pkg::MAX_BASIS_DEF,
  parameter int unsigned MAX_OCC   = ocp_pkg::MAX_OCC_DEF,
  parameter int unsigned MAX_VIRT  = ocp_pkg::MAX_VIRT_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [ocp_pkg::CFG_IW-1:0] cfg_idx_i,
  input  logic [ocp_pkg::CFG_DW-1:0] cfg_data_i,
  ocp_in_if.sink                     in_i,
  ocp_out_if.source                  out_o
);

  localparam int unsigned NBANDS = MAX_OCC + MAX_VIRT;
  localparam int unsigned IW = (MAX_BASIS > 1) ? $clog2(MAX_BASIS) : 1;
  localparam int unsigned BW = (NBANDS > 1) ? $clog2(NBANDS) : 1;
  localparam int unsigned OW = (MAX_OCC > 1) ? $clog2(MAX_OCC) : 1;
  localparam int unsigned VW = (MAX_VIRT > 1) ? $clog2(MAX_VIRT) : 1;

  ocp_pkg::dp_cmd_t cmd;
  logic [OW-1:0] amp_row;
  logic [VW-1:0] amp_col;
  logic [BW-1:0] c1_band, c2_band;
  logic [IW-1:0] mu, nu;

  // Sequencer.
  ocp_controller #(
    .MAX_BASIS(MAX_BASIS), .MAX_OCC(MAX_OCC), .MAX_VIRT(MAX_VIRT)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_i.valid),
    .in_mode_i   (in_i.mode),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .occ_index_o (out_o.occ_index),
    .virt_index_o(out_o.virt_index),
    .last_o      (out_o.last_result),
    .cmd_o       (cmd),
    .amp_row_o   (amp_row),
    .amp_col_o   (amp_col),
    .c1_band_o   (c1_band),
    .mu_o        (mu),
    .nu_o        (nu),
    .c2_band_o   (c2_band)
  );

  // Stores and arithmetic.
  ocp_datapath #(
    .MAX_BASIS(MAX_BASIS), .MAX_OCC(MAX_OCC), .MAX_VIRT(MAX_VIRT)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .mode_i    (in_i.mode),
    .row_i     (in_i.row_index),
    .col_i     (in_i.col_index),
    .value_i   (in_i.load_value),
    .amp_row_i (amp_row),
    .amp_col_i (amp_col),
    .c1_band_i (c1_band),
    .mu_i      (mu),
    .nu_i      (nu),
    .c2_band_i (c2_band),
    .result_o  (out_o.result_value)
  );

endmodule

// ----- sim/tb_orbital_potential_contraction.sv -----
// Testbench: self-checking stimulus and Q16.16 prediction for the contraction block.
`timescale 1ns / 1ps
module tb_orbital_potential_contraction;

  localparam int unsigned NB_MAX = ocp_pkg::MAX_BASIS_DEF;
  localparam int unsigned NO_MAX = ocp_pkg::MAX_OCC_DEF;
  localparam int unsigned NV_MAX = ocp_pkg::MAX_VIRT_DEF;
  localparam int unsigned WATCHDOG_LIMIT = 12000;
  localparam int unsigned HOLD_CYCLES = 400;
  // Basis columns filled for every band; wider settings only use band zero.
  localparam int unsigned FILL_COLS = 4;

  typedef struct {
    logic [2:0]         occ;
    logic [2:0]         virt;
    logic signed [31:0] value;
    logic               last;
  } result_t;

  // One row of the directed table; a typed result applies to 1x1x1 runs only.
  typedef struct {
    logic [1:0]         mode;
    logic [3:0]         row;
    logic [3:0]         col;
    logic signed [31:0] value;
    bit                 typed;
    logic signed [31:0] typed_value;
  } beat_row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [ocp_pkg::CFG_IW-1:0] cfg_idx_i;
  logic [ocp_pkg::CFG_DW-1:0] cfg_data_i;

  ocp_in_if  in_if ();
  ocp_out_if out_if ();

  orbital_potential_contraction dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_i      (in_if),
    .out_o     (out_if)
  );

  // Shadow of the block's stores and registers.
  logic signed [31:0] coef_mem [NO_MAX+NV_MAX][NB_MAX];
  logic signed [31:0] pot_mem  [NB_MAX][NB_MAX];
  logic signed [31:0] amp_mem  [NO_MAX][NV_MAX];
  logic [4:0] basis_reg;
  logic [3:0] occ_reg;
  logic [3:0] virt_reg;
  logic       term_reg;

  result_t pending_results[$];
  int      err_count;
  int      idle_cycles;
  bit      calm;
  bit      hold_req;

  // Clock.
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint sat_q(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Q16.16 multiply: add half, floor shift, saturate.
  function automatic longint mul_q(input longint a, input longint b);
    longint p;
    p = a * b + 64'sd32768;
    return sat_q(p >>> 16);
  endfunction

  function automatic int unsigned eff_count(input int unsigned v, input int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // Apply one accepted beat to the shadow stores; a compute beat queues its results.
  task automatic absorb_beat(input beat_row_t b);
    int unsigned nb, no, nv;
    longint acc, t;
    result_t r;
    case (b.mode)
      ocp_pkg::MODE_COEF: coef_mem[b.row][b.col] = b.value;
      ocp_pkg::MODE_POT:  pot_mem[b.row][b.col] = b.value;
      ocp_pkg::MODE_AMP: begin
        if (b.row < NO_MAX && b.col < NV_MAX) amp_mem[b.row][b.col] = b.value;
      end
      default: begin
        nb = eff_count(basis_reg, NB_MAX);
        no = eff_count(occ_reg, NO_MAX);
        nv = eff_count(virt_reg, NV_MAX);
        for (int i = 0; i < no; i++) begin
          for (int a = 0; a < nv; a++) begin
            acc = 0;
            for (int nu = 0; nu < nb; nu++) begin
              for (int mu = 0; mu < nb; mu++) begin
                if (!term_reg) begin
                  for (int j = 0; j < no; j++) begin
                    t = mul_q(amp_mem[j][a], coef_mem[i][mu]);
                    t = mul_q(t, pot_mem[nu][mu]);
                    acc += mul_q(t, coef_mem[j][nu]);
                  end
                end else begin
                  for (int j = 0; j < nv; j++) begin
                    t = mul_q(amp_mem[i][j], coef_mem[no+j][mu]);
                    t = mul_q(t, pot_mem[nu][mu]);
                    acc += mul_q(t, coef_mem[no+a][nu]);
                  end
                end
              end
            end
            r.occ   = i[2:0];
            r.virt  = a[2:0];
            r.value = 32'(sat_q(acc));
            r.last  = (i + 1 == no) && (a + 1 == nv);
            if (b.typed) r.value = b.typed_value;
            pending_results.push_back(r);
          end
        end
      end
    endcase
  endtask

  function automatic logic signed [31:0] rand_value();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) return $signed($urandom_range(0, 32'h40000)) - 32'sh20000;
    if (pick < 8) return $signed($urandom_range(0, 32'h400)) - 32'sh200;
    return $urandom;
  endfunction

  function automatic int unsigned rand_gap();
    int unsigned pick;
    if (calm) return 0;
    pick = $urandom_range(0, 9);
    if (pick < 5) return 0;
    if (pick < 9) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Drive one beat at the falling edge and wait for the handshake.
  task automatic send_beat(input beat_row_t b);
    int unsigned gap;
    gap = rand_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.mode       <= b.mode;
    in_if.row_index  <= b.row;
    in_if.col_index  <= b.col;
    in_if.load_value <= b.value;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    absorb_beat(b);
  endtask

  task automatic end_burst();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
  endtask

  // Let the block settle so the registers may be written.
  task automatic wait_quiet();
    end_burst();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (ocp_pkg::DRAIN_CYCLES + 4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [ocp_pkg::CFG_IW-1:0] idx,
                           input logic [ocp_pkg::CFG_DW-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      ocp_pkg::CFG_BASIS_COUNT: basis_reg = data;
      ocp_pkg::CFG_OCC_COUNT:   occ_reg = data[3:0];
      ocp_pkg::CFG_VIRT_COUNT:  virt_reg = data[3:0];
      ocp_pkg::CFG_TERM_MODE:   term_reg = data[0];
      default: ;
    endcase
  endtask

  task automatic set_counts(input int nb, input int no, input int nv, input int tm);
    write_reg(ocp_pkg::CFG_BASIS_COUNT, nb[4:0]);
    write_reg(ocp_pkg::CFG_OCC_COUNT, {1'b0, no[3:0]});
    write_reg(ocp_pkg::CFG_VIRT_COUNT, {1'b0, nv[3:0]});
    write_reg(ocp_pkg::CFG_TERM_MODE, {4'd0, tm[0]});
  endtask

  function automatic beat_row_t make_beat(input logic [1:0] m, input int r, input int c,
                                          input logic signed [31:0] v);
    beat_row_t b;
    b.mode = m;
    b.row = r[3:0];
    b.col = c[3:0];
    b.value = v;
    b.typed = 1'b0;
    b.typed_value = '0;
    return b;
  endfunction

  function automatic beat_row_t typed_compute(input logic signed [31:0] v);
    beat_row_t b;
    b = make_beat(ocp_pkg::MODE_COMPUTE, 0, 0, '0);
    b.typed = 1'b1;
    b.typed_value = v;
    return b;
  endfunction

  // Random phase: loads mixed with compute beats at the given percentage.
  task automatic random_phase(input int beats, input int compute_pct);
    beat_row_t b;
    for (int k = 0; k < beats; k++) begin
      if ($urandom_range(0, 99) < compute_pct) begin
        b = make_beat(ocp_pkg::MODE_COMPUTE, $urandom_range(0, 15), $urandom_range(0, 15),
                      $urandom);
      end else begin
        b = make_beat(2'($urandom_range(0, 2)), $urandom_range(0, 15),
                      $urandom_range(0, 15), rand_value());
      end
      send_beat(b);
    end
  endtask

  // Result receiver: random ready gaps, plus one long hold-off on request.
  int unsigned rx_gap;
  int unsigned rx_hold;
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      rx_gap  <= 0;
      rx_hold <= 0;
    end else if (hold_req && rx_hold == 0) begin
      rx_hold      <= HOLD_CYCLES;
      out_if.ready <= 1'b0;
    end else if (rx_hold > 1) begin
      rx_hold      <= rx_hold - 1;
      out_if.ready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_hold      <= 0;
      rx_gap       <= rx_gap - 1;
      out_if.ready <= 1'b0;
    end else begin
      rx_hold <= 0;
      if (!calm && $urandom_range(0, 9) < 3) begin
        rx_gap       <= ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
                                                    : $urandom_range(10, 40);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Result checker and watchdog.
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        err_count++;
        if (err_count <= 10) begin
          $display("unexpected result beat: occ %0d virt %0d value %h last %b",
                   out_if.occ_index, out_if.virt_index, out_if.result_value,
                   out_if.last_result);
        end
      end else begin
        want = pending_results.pop_front();
        if (out_if.occ_index !== want.occ || out_if.virt_index !== want.virt ||
            out_if.result_value !== want.value || out_if.last_result !== want.last) begin
          err_count++;
          if (err_count <= 10) begin
            $display("result mismatch: expected occ %0d virt %0d value %h last %b,",
                     want.occ, want.virt, want.value, want.last);
            $display("                 got occ %0d virt %0d value %h last %b",
                     out_if.occ_index, out_if.virt_index, out_if.result_value,
                     out_if.last_result);
          end
        end
      end
    end
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Main sequence.
  initial begin
    beat_row_t directed [$];
    err_count   = 0;
    idle_cycles = 0;
    calm        = 1'b0;
    hold_req    = 1'b0;
    basis_reg   = 5'd16;
    occ_reg     = 4'd8;
    virt_reg    = 4'd8;
    term_reg    = 1'b0;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_data_i  = '0;
    in_if.valid      = 1'b0;
    in_if.mode       = ocp_pkg::MODE_COEF;
    in_if.row_index  = '0;
    in_if.col_index  = '0;
    in_if.load_value = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Fill every store entry that a later compute reads: the low basis columns
    // of all bands, all basis columns of band zero, and the whole potential and
    // amplitude stores.
    calm = 1'b1;
    for (int r = 0; r < NO_MAX + NV_MAX; r++)
      for (int c = 0; c < FILL_COLS; c++)
        send_beat(make_beat(ocp_pkg::MODE_COEF, r, c, rand_value()));
    for (int c = FILL_COLS; c < NB_MAX; c++)
      send_beat(make_beat(ocp_pkg::MODE_COEF, 0, c, rand_value()));
    for (int r = 0; r < NB_MAX; r++)
      for (int c = 0; c < NB_MAX; c++)
        send_beat(make_beat(ocp_pkg::MODE_POT, r, c, rand_value()));
    for (int r = 0; r < NO_MAX; r++)
      for (int c = 0; c < NV_MAX; c++)
        send_beat(make_beat(ocp_pkg::MODE_AMP, r, c, rand_value()));
    calm = 1'b0;
    wait_quiet();

    // Directed part on a single-term setting.
    set_counts(1, 1, 1, 0);
    directed.push_back(make_beat(ocp_pkg::MODE_COEF, 0, 0, 32'sh10000));
    directed.push_back(make_beat(ocp_pkg::MODE_POT, 0, 0, 32'sh10000));
    directed.push_back(make_beat(ocp_pkg::MODE_AMP, 0, 0, 32'sh10000));
    directed.push_back(typed_compute(32'sh10000));
    directed.push_back(make_beat(ocp_pkg::MODE_COEF, 0, 0, 32'sh7fffffff));
    directed.push_back(make_beat(ocp_pkg::MODE_POT, 0, 0, 32'sh7fffffff));
    directed.push_back(make_beat(ocp_pkg::MODE_AMP, 0, 0, 32'sh7fffffff));
    directed.push_back(typed_compute(32'sh7fffffff));
    directed.push_back(make_beat(ocp_pkg::MODE_COEF, 0, 0, 32'sh80000000));
    directed.push_back(make_beat(ocp_pkg::MODE_POT, 0, 0, 32'sh80000000));
    directed.push_back(make_beat(ocp_pkg::MODE_AMP, 0, 0, 32'sh80000000));
    directed.push_back(typed_compute(32'sh7fffffff));
    directed.push_back(make_beat(ocp_pkg::MODE_COEF, 0, 0, 32'sh7fffffff));
    directed.push_back(make_beat(ocp_pkg::MODE_AMP, 0, 0, 32'sh10000));
    directed.push_back(typed_compute(32'sh80000000));
    // Rounding ties: half an LSB rounds up, minus half rounds to zero.
    directed.push_back(make_beat(ocp_pkg::MODE_COEF, 0, 0, 32'sh8000));
    directed.push_back(make_beat(ocp_pkg::MODE_POT, 0, 0, 32'sh10000));
    directed.push_back(make_beat(ocp_pkg::MODE_AMP, 0, 0, 32'sh1));
    directed.push_back(typed_compute(32'sh1));
    directed.push_back(make_beat(ocp_pkg::MODE_AMP, 0, 0, -32'sh1));
    // Amplitude loads outside the store are dropped.
    directed.push_back(make_beat(ocp_pkg::MODE_AMP, 8, 0, 32'sh10000));
    directed.push_back(make_beat(ocp_pkg::MODE_AMP, 0, 8, 32'sh10000));
    directed.push_back(make_beat(ocp_pkg::MODE_AMP, 15, 15, 32'sh10000));
    directed.push_back(typed_compute(32'sh0));
    foreach (directed[k]) send_beat(directed[k]);
    wait_quiet();

    // Virtual term and zero counts acting as one.
    set_counts(0, 0, 0, 1);
    send_beat(make_beat(ocp_pkg::MODE_COMPUTE, 15, 15, '0));
    wait_quiet();

    // Basis count beyond its limit, then band counts beyond theirs in both terms.
    set_counts(31, 1, 1, 0);
    send_beat(make_beat(ocp_pkg::MODE_COMPUTE, 0, 0, '0));
    wait_quiet();
    set_counts(1, 15, 15, 0);
    send_beat(make_beat(ocp_pkg::MODE_COMPUTE, 0, 0, '0));
    wait_quiet();
    set_counts(1, 15, 15, 1);
    send_beat(make_beat(ocp_pkg::MODE_COMPUTE, 0, 0, '0));
    wait_quiet();

    // Long receiver hold-off while loads keep coming behind a compute beat.
    set_counts(2, 3, 3, 0);
    send_beat(make_beat(ocp_pkg::MODE_COMPUTE, 0, 0, '0));
    hold_req = 1'b1;
    @(posedge clk_i);
    @(posedge clk_i);
    hold_req = 1'b0;
    random_phase(6, 0);
    wait_quiet();

    // Random phases over small settings.
    for (int p = 0; p < 3; p++) begin
      calm = (p == 2);
      set_counts($urandom_range(0, FILL_COLS), $urandom_range(0, 4), $urandom_range(0, 4),
                 $urandom_range(0, 1));
      random_phase(8, 15);
      wait_quiet();
    end
    calm = 1'b0;

    repeat (ocp_pkg::DRAIN_CYCLES + 10) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      err_count++;
      $display("%0d expected results never arrived", pending_results.size());
    end
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
